/* rtl/eus_pkg.sv */
// Shared widths, register indexes, direction codes and unit status type
// for the encoder unwrap and speed estimator. No dependencies.
package eus_pkg;

    // Field widths
    localparam int RAW_BITS   = 8;
    localparam int POS_BITS   = 32;
    localparam int TIME_BITS  = 32;
    localparam int STEP_BITS  = 8;
    localparam int GAIN_BITS  = 16;
    localparam int DELTA_BITS = RAW_BITS + 1;
    localparam int MAG_BITS   = RAW_BITS;
    localparam int PROD_BITS  = MAG_BITS + GAIN_BITS;
    localparam int SPEED_BITS = 32;
    localparam int DIR_BITS   = 2;

    // Serial unit step counters
    localparam int MUL_CNT_BITS = $clog2(GAIN_BITS);
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS);

    // Stream packing
    localparam int IN_FIELD_BITS  = RAW_BITS + TIME_BITS;
    localparam int IN_BITS        = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = POS_BITS + DELTA_BITS + TIME_BITS + SPEED_BITS
                                    + DIR_BITS + 1;
    localparam int OUT_BITS       = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_BITS - OUT_FIELD_BITS;

    // Configuration port
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = GAIN_BITS;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_STEP   = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_GAIN = 8'd1;
    localparam logic [STEP_BITS-1:0]    MAX_STEP_RST   = 8'd100;
    localparam logic [GAIN_BITS-1:0]    SPEED_GAIN_RST = 16'd256;

    // Direction codes
    localparam logic [DIR_BITS-1:0] DIR_RELEASE  = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_FORWARD  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_BACKWARD = 2'd2;

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

/* rtl/eus_mul.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on eus_pkg.
module eus_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [eus_pkg::MAG_BITS-1:0]   mcand,
    input  logic [eus_pkg::GAIN_BITS-1:0]  mplier,
    output logic [eus_pkg::PROD_BITS-1:0]  product,
    output eus_pkg::unit_stat_t            stat
);

    logic [eus_pkg::MAG_BITS-1:0]     hi_reg, hi_next;
    logic [eus_pkg::GAIN_BITS-1:0]    lo_reg, lo_next;
    logic [eus_pkg::MAG_BITS-1:0]     mcand_reg;
    logic [eus_pkg::MUL_CNT_BITS-1:0] cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [eus_pkg::MAG_BITS:0]       sum;
    logic                             last_step;

    // One add of the multiplicand, then shift the product pair right
    always_comb
    begin
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg}
                                                : {(eus_pkg::MAG_BITS+1){1'b0}});
        hi_next   = sum[eus_pkg::MAG_BITS:1];
        lo_next   = {sum[0], lo_reg[eus_pkg::GAIN_BITS-1:1]};
        last_step = cnt_reg == eus_pkg::MUL_CNT_BITS'(eus_pkg::GAIN_BITS - 1);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg    <= '0;
            lo_reg    <= mplier;
            mcand_reg <= mcand;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign product   = {hi_reg, lo_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/eus_div.sv */
// Restoring divider: one quotient bit per cycle, MSB first.
// Depends on eus_pkg.
module eus_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [eus_pkg::PROD_BITS-1:0]  dividend,
    input  logic [eus_pkg::TIME_BITS-1:0]  divisor,
    output logic [eus_pkg::PROD_BITS-1:0]  quotient,
    output eus_pkg::unit_stat_t            stat
);

    logic [eus_pkg::TIME_BITS-1:0]    rem_reg, rem_next;
    logic [eus_pkg::PROD_BITS-1:0]    quo_reg, quo_next;
    logic [eus_pkg::TIME_BITS-1:0]    dvs_reg;
    logic [eus_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [eus_pkg::TIME_BITS:0]      shifted;
    logic [eus_pkg::TIME_BITS+1:0]    diff;
    logic                             ge;
    logic                             last_step;

    // Bring down the next dividend bit and try a subtract
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[eus_pkg::PROD_BITS-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        ge        = !diff[eus_pkg::TIME_BITS+1];
        rem_next  = ge ? diff[eus_pkg::TIME_BITS-1:0] : shifted[eus_pkg::TIME_BITS-1:0];
        quo_next  = {quo_reg[eus_pkg::PROD_BITS-2:0], ge};
        last_step = cnt_reg == eus_pkg::DIV_CNT_BITS'(eus_pkg::PROD_BITS - 1);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/encoder_unwrap_speed_estimator.sv */
// Top level of the encoder unwrap and speed estimator.
// Depends on eus_pkg, eus_mul and eus_div.
//
// Usage:
//   s_* carries one sample per request: an encoder reading and a ms timestamp.
//   m_* returns one result per sample: unwrapped position, corrected step,
//   time delta, Q.8 speed, direction and a zero-time flag.
//   cfg_* writes max_step (index 0) and speed_gain (index 1); other indexes
//   are ignored. Write only while no sample is in flight.
// Operation:
//   Unwrap and time delta are formed in the accept cycle. |step| * gain then
//   runs on a bit-serial multiplier (one gain bit per step), and the
//   product is divided by the time delta on a restoring divider (one
//   quotient bit per step); the divide is skipped when the time delta is
//   zero. One sample is in work at a time, so no new sample is accepted
//   until its result has moved to the output register.
// Reset: position and last time clear to zero, registers return to
//   max_step = 100 and speed_gain = 256, no result is pending.
// Stall: the result sits in an output register; a new sample is accepted
//   while it waits, and the finished next result holds until it drains.
module encoder_unwrap_speed_estimator (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: raw_reading[7:0], sample_time[39:8]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [eus_pkg::IN_BITS-1:0]       s_tdata,
    // m_tdata: position[31:0], delta_position[40:32], delta_time[72:41],
    //          speed[104:73], direction[106:105], time_zero[107], zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [eus_pkg::OUT_BITS-1:0]      m_tdata,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [eus_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [eus_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [eus_pkg::STEP_BITS-1:0]  max_step_reg;
    logic [eus_pkg::GAIN_BITS-1:0]  speed_gain_reg;
    logic [eus_pkg::POS_BITS-1:0]   last_pos_reg;
    logic [eus_pkg::TIME_BITS-1:0]  last_time_reg;

    // per-sample work registers
    logic [eus_pkg::POS_BITS-1:0]   pos_reg;
    logic [eus_pkg::DELTA_BITS-1:0] delta_reg;
    logic [eus_pkg::TIME_BITS-1:0]  dt_reg;
    logic [eus_pkg::DIR_BITS-1:0]   dir_reg;
    logic                           neg_reg;
    logic                           tz_reg;

    logic                           m_tvalid_reg;
    logic [eus_pkg::OUT_BITS-1:0]   m_tdata_reg;

    logic                           s_accept;
    logic                           out_free;
    logic                           out_load;
    logic [eus_pkg::RAW_BITS-1:0]   reading;
    logic [eus_pkg::TIME_BITS-1:0]  now;
    logic [eus_pkg::RAW_BITS-1:0]   prev_raw;
    logic [eus_pkg::DELTA_BITS-1:0] d_raw;
    logic [eus_pkg::DELTA_BITS-1:0] mag_raw;
    logic [eus_pkg::DELTA_BITS-1:0] d_sel;
    logic [eus_pkg::DELTA_BITS-1:0] mag_sel;
    logic [eus_pkg::POS_BITS-1:0]   pos_new;
    logic [eus_pkg::TIME_BITS-1:0]  dt_new;
    logic [eus_pkg::DIR_BITS-1:0]   dir_new;

    logic                           div_start;
    logic [eus_pkg::PROD_BITS-1:0]  product;
    logic [eus_pkg::PROD_BITS-1:0]  quotient;
    eus_pkg::unit_stat_t            mul_stat;
    eus_pkg::unit_stat_t            div_stat;
    logic [eus_pkg::SPEED_BITS-1:0] q_ext;
    logic [eus_pkg::SPEED_BITS-1:0] speed;

    assign s_tready  = state_reg == S_IDLE;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == S_DONE) && out_free;
    assign div_start = (state_reg == S_MUL) && mul_stat.done && !tz_reg;

    // Unwrap the reading against the low bits of the last position
    always_comb
    begin
        reading  = s_tdata[eus_pkg::RAW_BITS-1:0];
        now      = s_tdata[eus_pkg::RAW_BITS +: eus_pkg::TIME_BITS];
        prev_raw = last_pos_reg[eus_pkg::RAW_BITS-1:0];
        d_raw    = {reading[eus_pkg::RAW_BITS-1], reading}
                 - {prev_raw[eus_pkg::RAW_BITS-1], prev_raw};
        mag_raw  = d_raw[eus_pkg::DELTA_BITS-1] ? -d_raw : d_raw;
        // wrap correction: adding or subtracting one full turn flips the top bit
        if (mag_raw > eus_pkg::DELTA_BITS'(max_step_reg))
            d_sel = {~d_raw[eus_pkg::DELTA_BITS-1], d_raw[eus_pkg::DELTA_BITS-2:0]};
        else
            d_sel = d_raw;
        mag_sel = d_sel[eus_pkg::DELTA_BITS-1] ? -d_sel : d_sel;
        pos_new = last_pos_reg
                + {{(eus_pkg::POS_BITS-eus_pkg::DELTA_BITS){d_sel[eus_pkg::DELTA_BITS-1]}},
                   d_sel};
        dt_new  = now - last_time_reg;
        if (d_sel[eus_pkg::DELTA_BITS-1])
            dir_new = eus_pkg::DIR_BACKWARD;
        else if (|d_sel)
            dir_new = eus_pkg::DIR_FORWARD;
        else
            dir_new = eus_pkg::DIR_RELEASE;
    end

    // Configuration registers and sample history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg   <= eus_pkg::MAX_STEP_RST;
            speed_gain_reg <= eus_pkg::SPEED_GAIN_RST;
            last_pos_reg   <= '0;
            last_time_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == eus_pkg::REG_MAX_STEP)
                max_step_reg <= cfg_data[eus_pkg::STEP_BITS-1:0];
            if (cfg_valid && cfg_index == eus_pkg::REG_SPEED_GAIN)
                speed_gain_reg <= cfg_data[eus_pkg::GAIN_BITS-1:0];
            if (s_accept)
            begin
                last_pos_reg  <= pos_new;
                last_time_reg <= now;
            end
        end
    end

    // Capture the sample's results that need no arithmetic unit
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            pos_reg   <= pos_new;
            delta_reg <= d_sel;
            dt_reg    <= dt_new;
            dir_reg   <= dir_new;
            neg_reg   <= d_sel[eus_pkg::DELTA_BITS-1];
            tz_reg    <= dt_new == '0;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_accept)
                    state_next = S_MUL;
            S_MUL:
                if (mul_stat.done)
                    state_next = tz_reg ? S_DONE : S_DIV;
            S_DIV:
                if (div_stat.done)
                    state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // |step| * gain, then divided by the time delta
    eus_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (s_accept),
        .mcand   (mag_sel[eus_pkg::MAG_BITS-1:0]),
        .mplier  (speed_gain_reg),
        .product (product),
        .stat    (mul_stat)
    );

    eus_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (dt_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Signed speed; the quotient is far below the 32-bit signed limit
    always_comb
    begin
        q_ext = tz_reg ? '0
                       : {{(eus_pkg::SPEED_BITS-eus_pkg::PROD_BITS){1'b0}}, quotient};
        speed = neg_reg ? -q_ext : q_ext;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= {{eus_pkg::OUT_PAD_BITS{1'b0}}, tz_reg, dir_reg, speed,
                            dt_reg, delta_reg, pos_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sim/tb_encoder_unwrap_speed_estimator.sv */
// Self-checking testbench for encoder_unwrap_speed_estimator: directed table, then random
// sample streams under several register settings and idle patterns. Depends on eus_pkg.
`timescale 1ns / 100ps

module tb_encoder_unwrap_speed_estimator;

    // One result as it sits in m_tdata, lowest field last
    typedef struct packed {
        logic                          time_zero;
        logic [eus_pkg::DIR_BITS-1:0]  direction;
        logic signed [31:0]            speed;
        logic [31:0]                   delta_time;
        logic signed [8:0]             delta_position;
        logic signed [31:0]            position;
    } motion_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [7:0]            reg_index;
        logic [15:0]           reg_value;
        logic signed [7:0]     raw;
        logic [31:0]           stamp;
        logic                  typed;
        motion_t               want;
    } directed_row_t;

    localparam logic [eus_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED = 8'hFF;
    localparam int SEGMENTS     = 6;
    localparam int SEG_SAMPLES  = 160;
    localparam int SETTLE_CYCLES = 60;

    localparam motion_t NO_CHECK = '0;

    // Directed rows; want = '{time_zero, direction, speed, delta_time, delta_position, position}
    localparam directed_row_t DIRECTED_ROWS [22] = '{
        // after reset: zero step, zero time delta
        '{ROW_SAMPLE, 8'd0, 16'd0, 8'sd0, 32'd0, 1'b1,
          '{1'b1, eus_pkg::DIR_RELEASE, 32'sd0, 32'd0, 9'sd0, 32'sd0}},
        // jump of +127 is corrected to -129
        '{ROW_SAMPLE, 8'd0, 16'd0, 8'sd127, 32'd1, 1'b1,
          '{1'b0, eus_pkg::DIR_BACKWARD, -32'sd33024, 32'd1, -9'sd129, -32'sd129}},
        // -255 corrected to +1
        '{ROW_SAMPLE, 8'd0, 16'd0, -8'sd128, 32'd3, 1'b1,
          '{1'b0, eus_pkg::DIR_FORWARD, 32'sd128, 32'd2, 9'sd1, -32'sd128}},
        // repeated sample: zero time delta
        '{ROW_SAMPLE, 8'd0, 16'd0, -8'sd128, 32'd3, 1'b1,
          '{1'b1, eus_pkg::DIR_RELEASE, 32'sd0, 32'd0, 9'sd0, -32'sd128}},
        // huge time delta truncates speed to zero
        '{ROW_SAMPLE, 8'd0, 16'd0, 8'sd100, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, eus_pkg::DIR_BACKWARD, 32'sd0, 32'hFFFF_FFFC, -9'sd28, -32'sd156}},
        // timestamp wraps; step exactly at threshold is kept
        '{ROW_SAMPLE, 8'd0, 16'd0, 8'sd0, 32'd4, 1'b1,
          '{1'b0, eus_pkg::DIR_BACKWARD, -32'sd5120, 32'd5, -9'sd100, -32'sd256}},
        // one past threshold
        '{ROW_SAMPLE, 8'd0, 16'd0, 8'sd101, 32'd20, 1'b1,
          '{1'b0, eus_pkg::DIR_BACKWARD, -32'sd2480, 32'd16, -9'sd155, -32'sd411}},
        '{ROW_WRITE, eus_pkg::REG_MAX_STEP, 16'd0, 8'sd0, 32'd0, 1'b0, NO_CHECK},
        '{ROW_WRITE, eus_pkg::REG_SPEED_GAIN, 16'hFFFF, 8'sd0, 32'd0, 1'b0, NO_CHECK},
        // threshold zero, no motion
        '{ROW_SAMPLE, 8'd0, 16'd0, 8'sd101, 32'd20, 1'b1,
          '{1'b1, eus_pkg::DIR_RELEASE, 32'sd0, 32'd0, 9'sd0, -32'sd411}},
        // threshold zero, -128 flips to +128, max gain
        '{ROW_SAMPLE, 8'd0, 16'd0, -8'sd27, 32'd21, 1'b1,
          '{1'b0, eus_pkg::DIR_FORWARD, 32'sd8388480, 32'd1, 9'sd128, -32'sd283}},
        // threshold zero, +1 becomes -255: largest speed magnitude
        '{ROW_SAMPLE, 8'd0, 16'd0, -8'sd26, 32'd22, 1'b1,
          '{1'b0, eus_pkg::DIR_BACKWARD, -32'sd16711425, 32'd1, -9'sd255, -32'sd538}},
        '{ROW_WRITE, eus_pkg::REG_SPEED_GAIN, 16'd0, 8'sd0, 32'd0, 1'b0, NO_CHECK},
        // zero gain
        '{ROW_SAMPLE, 8'd0, 16'd0, 8'sd127, 32'd1000, 1'b1,
          '{1'b0, eus_pkg::DIR_BACKWARD, 32'sd0, 32'd978, -9'sd103, -32'sd641}},
        '{ROW_WRITE, eus_pkg::REG_MAX_STEP, 16'd255, 8'sd0, 32'd0, 1'b0, NO_CHECK},
        '{ROW_WRITE, eus_pkg::REG_SPEED_GAIN, 16'd1, 8'sd0, 32'd0, 1'b0, NO_CHECK},
        // full-scale steps pass uncorrected
        '{ROW_SAMPLE, 8'd0, 16'd0, -8'sd128, 32'd1000, 1'b1,
          '{1'b1, eus_pkg::DIR_BACKWARD, 32'sd0, 32'd0, -9'sd255, -32'sd896}},
        '{ROW_SAMPLE, 8'd0, 16'd0, 8'sd127, 32'd1255, 1'b1,
          '{1'b0, eus_pkg::DIR_FORWARD, 32'sd1, 32'd255, 9'sd255, -32'sd641}},
        // unmapped register index is ignored
        '{ROW_WRITE, REG_UNMAPPED, 16'hFFFF, 8'sd0, 32'd0, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 8'd0, 16'd0, 8'sd127, 32'h8000_0000, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 8'd0, 16'd0, 8'sd0, 32'hFFFF_FFFF, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 8'd0, 16'd0, -8'sd1, 32'h7FFF_FFFF, 1'b0, NO_CHECK}
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [eus_pkg::IN_BITS-1:0]       s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [eus_pkg::OUT_BITS-1:0]      m_tdata;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [eus_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [eus_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    // Predictor state and register shadow
    logic [31:0]                       track_pos = '0;
    logic [31:0]                       track_time = '0;
    logic [eus_pkg::STEP_BITS-1:0]     cur_max_step = eus_pkg::MAX_STEP_RST;
    logic [eus_pkg::GAIN_BITS-1:0]     cur_gain = eus_pkg::SPEED_GAIN_RST;

    motion_t                  expected_motion [$];
    int                       mismatch_count = 0;
    int                       send_idle_pct = 6;
    int                       recv_idle_pct = 85;

    encoder_unwrap_speed_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Unwrap one sample, advance the tracked state, return the expected result
    function automatic motion_t predict_motion(input logic signed [7:0] raw,
                                               input logic [31:0] stamp);
        int      prev_raw;
        int      step;
        int      mag;
        int      up;
        int      down;
        longint  quot;
        motion_t r;
        prev_raw = int'($signed(track_pos[7:0]));
        step = int'(raw) - prev_raw;
        mag = (step < 0) ? -step : step;
        if (mag > int'(cur_max_step))
        begin
            up = step + 256;
            down = step - 256;
            step = (((up < 0) ? -up : up) <= ((down < 0) ? -down : down)) ? up : down;
            mag = (step < 0) ? -step : step;
        end
        r.position = track_pos + 32'(step);
        r.delta_position = 9'(step);
        r.delta_time = stamp - track_time;
        r.time_zero = (r.delta_time == 32'd0);
        r.speed = '0;
        if (!r.time_zero)
        begin
            quot = (longint'(mag) * longint'(cur_gain)) / longint'(r.delta_time);
            if (step < 0)
                r.speed = 32'((quot > 64'sh8000_0000) ? -64'sh8000_0000 : -quot);
            else
                r.speed = 32'((quot > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : quot);
        end
        r.direction = (step > 0) ? eus_pkg::DIR_FORWARD
                    : ((step < 0) ? eus_pkg::DIR_BACKWARD : eus_pkg::DIR_RELEASE);
        track_pos = r.position;
        track_time = stamp;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
        end
    endfunction

    // Stop sending and wait until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_motion.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [eus_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [eus_pkg::CFG_DATA_BITS-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == eus_pkg::REG_MAX_STEP)
            cur_max_step = value[eus_pkg::STEP_BITS-1:0];
        else if (idx == eus_pkg::REG_SPEED_GAIN)
            cur_gain = value;
    endtask

    // Offer one sample request; on accept, queue its expected result
    task automatic send_sample(input logic signed [7:0] raw, input logic [31:0] stamp,
                               input logic typed, input motion_t typed_want);
        motion_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {stamp, raw};
        do @(posedge clk); while (!s_tready);
        want = predict_motion(raw, stamp);
        expected_motion.push_back(typed ? typed_want : want);
    endtask

    // Random sample: mostly smooth motion, some threshold probes and noise
    task automatic send_random_sample();
        int                pick;
        int                step;
        logic signed [7:0] raw;
        logic [31:0]       stamp;
        pick = $urandom_range(99);
        if (pick < 70)
            step = int'($urandom_range(40)) - 20;
        else if (pick < 88)
            step = (int'(cur_max_step) + int'($urandom_range(2)) - 1)
                   * (($urandom_range(1) == 1) ? 1 : -1);
        else
            step = int'($urandom_range(255));
        raw = 8'(int'(track_pos[7:0]) + step);
        pick = $urandom_range(99);
        if (pick < 65)
            stamp = track_time + 32'($urandom_range(1, 20));
        else if (pick < 78)
            stamp = track_time;
        else if (pick < 90)
            stamp = track_time + 32'($urandom_range(1, 5000));
        else
            stamp = $urandom;
        if ($urandom_range(99) == 0)
            wait_drained();
        send_sample(raw, stamp, 1'b0, NO_CHECK);
    endtask

    // Result side: random stall, compare each accepted result
    always @(posedge clk)
    begin : result_check
        motion_t want;
        motion_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[eus_pkg::OUT_FIELD_BITS-1:0];
            if (expected_motion.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
            end
            else
            begin
                want = expected_motion.pop_front();
                check_field("position", want.position, got.position);
                check_field("delta_position", 32'(want.delta_position), 32'(got.delta_position));
                check_field("delta_time", want.delta_time, got.delta_time);
                check_field("speed", want.speed, got.speed);
                check_field("direction", 32'(want.direction), 32'(got.direction));
                check_field("time_zero", 32'(want.time_zero), 32'(got.time_zero));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Main stimulus
    initial
    begin
        logic [eus_pkg::STEP_BITS-1:0] step_val;
        logic [eus_pkg::GAIN_BITS-1:0] gain_val;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind == ROW_WRITE)
                write_register(DIRECTED_ROWS[i].reg_index, DIRECTED_ROWS[i].reg_value);
            else
                send_sample(DIRECTED_ROWS[i].raw, DIRECTED_ROWS[i].stamp,
                            DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            // idle pattern: sender light / receiver heavy, then swapped, then none
            case (seg / 2)
                0:       begin send_idle_pct = 6;  recv_idle_pct = 85; end
                1:       begin send_idle_pct = 85; recv_idle_pct = 6;  end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (seg)
                0:       begin step_val = 8'd0;   gain_val = 16'hFFFF; end
                1:       begin step_val = 8'd255; gain_val = 16'd1;    end
                2:       begin step_val = 8'd100; gain_val = 16'd256;  end
                3:       begin step_val = 8'd127; gain_val = 16'd0;    end
                default: begin step_val = 8'($urandom); gain_val = 16'($urandom); end
            endcase
            write_register(eus_pkg::REG_MAX_STEP, eus_pkg::CFG_DATA_BITS'(step_val));
            write_register(eus_pkg::REG_SPEED_GAIN, gain_val);
            repeat (SEG_SAMPLES) send_random_sample();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_encoder_unwrap_speed_estimator OK");
        else
            $display("tb_encoder_unwrap_speed_estimator NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("tb_encoder_unwrap_speed_estimator NOT OK");
        $finish;
    end

endmodule
